>>> hdl/rcfe_pkg.sv
// Shared types and constants for the RC channel frame encoder.
// No dependencies; every other file in the project imports this package.
package rcfe_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W       = 11;
	localparam int IDX_W        = $clog2(NUM_CHANNELS);
	localparam int ACC_W        = CHAN_W + 7;
	localparam int CNT_W        = 5;
	localparam int CFG_IDX_W    = 8;

	localparam logic [CHAN_W-1:0] RESET_CENTER = 11'd992;
	localparam logic [7:0]        FRAME_LEN    = 8'd24;
	localparam logic [7:0]        CRC_POLY     = 8'hD5;
	localparam logic [4:0]        CHAN_BITS    = 5'd11;
	localparam logic [4:0]        BYTE_BITS    = 5'd8;

	localparam logic [CNT_W-1:0] POS_SYNC      = 5'd0;
	localparam logic [CNT_W-1:0] POS_LEN       = 5'd1;
	localparam logic [CNT_W-1:0] POS_KIND      = 5'd2;
	localparam logic [CNT_W-1:0] POS_PAY_FIRST = 5'd3;
	localparam logic [CNT_W-1:0] POS_PAY_LAST  = 5'd24;
	localparam logic [CNT_W-1:0] POS_CRC       = 5'd25;

	localparam logic [1:0] KIND_SET  = 2'd0;
	localparam logic [1:0] KIND_SEND = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 8'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  channel_number;
		logic [15:0] channel_value;
	} cmd_t;

	typedef struct packed {
		logic [CHAN_W-1:0] data;
		logic              is_frame_byte;
		logic              last;
	} result_t;

	typedef struct packed {
		logic clear;
		logic step;
	} step_ctl_t;

endpackage

>>> hdl/rc_channel_frame_encoder_top.sv
// Set items give no result; a read answer is registered and appears in the cycle after start.
// A send item gives 26 frame bytes on consecutive cycles, the first once busy and then the result register are loaded;
// busy stays high until the CRC byte is sent, paced by the byte counter and the one-byte-per-cycle packer.
// A new item may start on the cycle busy falls, while the final frame byte is on the outputs.
// Asynchronous active-low reset sets all channels to 992 and the registers to their defaults.
// Depends on rcfe_pkg, rcfe_chan_store, rcfe_packer and rcfe_crc8.
module rc_channel_frame_encoder_top
	import rcfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 strobe,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAN_W-1:0]    cfg_data
);

	logic [7:0]        sync_q;
	logic [7:0]        kind_code_q;
	logic [CHAN_W-1:0] clamp_low_q;
	logic [CHAN_W-1:0] clamp_high_q;
	logic [CHAN_W-1:0] center_q;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              strobe_q;
	result_t           result_q;

	logic              accept;
	logic              chan_ok;
	logic [IDX_W-1:0]  cmd_idx;
	logic              in_payload;
	step_ctl_t         pack_ctl;
	step_ctl_t         crc_ctl;
	logic [IDX_W-1:0]  pack_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic [CHAN_W-1:0] rd_value;
	logic [7:0]        pack_byte;
	logic [7:0]        crc_in;
	logic [7:0]        crc_value;
	logic [7:0]        frame_byte;
	logic [7:0]        chan_m1;

	assign accept    = start && !busy_q;
	assign chan_ok   = (cmd.channel_number != 8'd0) &&
	                   (cmd.channel_number <= 8'(NUM_CHANNELS));
	assign chan_m1   = cmd.channel_number - 8'd1;
	assign cmd_idx   = chan_m1[IDX_W-1:0];
	assign in_payload = (cnt_q >= POS_PAY_FIRST) && (cnt_q <= POS_PAY_LAST);
	assign rd_idx    = busy_q ? pack_idx : cmd_idx;

	always_comb begin
		pack_ctl.clear = accept && (cmd.kind == KIND_SEND);
		pack_ctl.step  = busy_q && in_payload;
		crc_ctl.clear  = pack_ctl.clear;
		crc_ctl.step   = busy_q && (in_payload || (cnt_q == POS_KIND));
		crc_in         = (cnt_q == POS_KIND) ? kind_code_q : pack_byte;
	end

	always_comb begin
		case (cnt_q)
			POS_SYNC: frame_byte = sync_q;
			POS_LEN:  frame_byte = FRAME_LEN;
			POS_KIND: frame_byte = kind_code_q;
			POS_CRC:  frame_byte = crc_value;
			default:  frame_byte = pack_byte;
		endcase
	end

	rcfe_chan_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && (cmd.kind == KIND_SET) && chan_ok),
		.wr_idx     (cmd_idx),
		.wr_value   (cmd.channel_value),
		.clamp_low  (clamp_low_q),
		.clamp_high (clamp_high_q),
		.rd_idx     (rd_idx),
		.rd_value   (rd_value)
	);

	rcfe_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pack_ctl),
		.ch_value (rd_value),
		.ch_idx   (pack_idx),
		.byte_out (pack_byte)
	);

	rcfe_crc8 u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (crc_ctl),
		.byte_in (crc_in),
		.crc     (crc_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= 8'd200;
			kind_code_q  <= 8'd22;
			clamp_low_q  <= 11'd172;
			clamp_high_q <= 11'd1811;
			center_q     <= RESET_CENTER;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SYNC:   sync_q       <= cfg_data[7:0];
				REG_KIND:   kind_code_q  <= cfg_data[7:0];
				REG_LOW:    clamp_low_q  <= cfg_data;
				REG_HIGH:   clamp_high_q <= cfg_data;
				REG_CENTER: center_q     <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (busy_q) begin
				strobe_q               <= 1'b1;
				result_q.data          <= {3'd0, frame_byte};
				result_q.is_frame_byte <= 1'b1;
				result_q.last          <= (cnt_q == POS_CRC);
				cnt_q                  <= cnt_q + 1'b1;
				if (cnt_q == POS_CRC) begin
					busy_q <= 1'b0;
				end
			end else if (accept) begin
				if (cmd.kind == KIND_SEND) begin
					busy_q <= 1'b1;
					cnt_q  <= POS_SYNC;
				end else if (cmd.kind == KIND_READ) begin
					strobe_q               <= 1'b1;
					result_q.data          <= chan_ok ? rd_value : center_q;
					result_q.is_frame_byte <= 1'b0;
					result_q.last          <= 1'b1;
				end
			end
		end
	end

	assign busy      = busy_q;
	assign strobe    = strobe_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
	a_read_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.is_frame_byte |-> result.last)
		else $error("read answer not marked last");

	a_crc_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == POS_CRC) |=> !busy_q && strobe_q && result_q.last)
		else $error("frame did not end after the CRC byte");

	a_busy_from_send: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start && (cmd.kind == KIND_SEND)))
		else $error("busy rose without a send transaction");

	a_frame_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last && result.is_frame_byte |-> !busy_q)
		else $error("final frame byte while still busy");

	a_busy_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$rose(busy_q) |-> strobe_q && result_q.is_frame_byte)
		else $error("gap in frame byte stream");
`endif

endmodule

>>> hdl/rcfe_chan_store.sv
// Channel value store with clamping on write.
// Depends on rcfe_pkg for widths and the reset center value.
module rcfe_chan_store
	import rcfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [15:0]       wr_value,
	input  logic [CHAN_W-1:0] clamp_low,
	input  logic [CHAN_W-1:0] clamp_high,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [CHAN_W-1:0] rd_value
);

	logic [CHAN_W-1:0] store_q [NUM_CHANNELS];
	logic [15:0]       raised;
	logic [15:0]       clamped;

	always_comb begin
		raised  = (wr_value < {5'd0, clamp_low}) ? {5'd0, clamp_low} : wr_value;
		clamped = (raised > {5'd0, clamp_high}) ? {5'd0, clamp_high} : raised;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				store_q[i] <= RESET_CENTER;
			end
		end else if (wr_en) begin
			store_q[wr_idx] <= clamped[CHAN_W-1:0];
		end
	end

	assign rd_value = store_q[rd_idx];

endmodule

>>> hdl/rcfe_packer.sv
// Byte-serial packer that turns 11-bit channels into LSB-first payload bytes.
// Depends on rcfe_pkg; reads one channel at a time from the channel store.
module rcfe_packer
	import rcfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  step_ctl_t         ctl,
	input  logic [CHAN_W-1:0] ch_value,
	output logic [IDX_W-1:0]  ch_idx,
	output logic [7:0]        byte_out
);

	logic [ACC_W-1:0] acc_q;
	logic [4:0]       have_q;
	logic [IDX_W-1:0] idx_q;
	logic             need;
	logic [ACC_W-1:0] ext;
	logic [ACC_W-1:0] merged;
	logic [4:0]       have_next;

	always_comb begin
		need      = have_q < BYTE_BITS;
		ext       = {7'd0, ch_value} << have_q[2:0];
		merged    = need ? (acc_q | ext) : acc_q;
		have_next = need ? (have_q + CHAN_BITS) : have_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= '0;
			idx_q  <= '0;
			acc_q  <= '0;
		end else if (ctl.clear) begin
			have_q <= '0;
			idx_q  <= '0;
			acc_q  <= '0;
		end else if (ctl.step) begin
			acc_q  <= {8'd0, merged[ACC_W-1:8]};
			have_q <= have_next - BYTE_BITS;
			if (need) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign ch_idx   = idx_q;
	assign byte_out = merged[7:0];

endmodule

>>> hdl/rcfe_crc8.sv
// Running CRC-8 (polynomial 0xD5, zero start) updated one byte per cycle while step is high.
// Depends on rcfe_pkg for the polynomial and the control struct.
module rcfe_crc8
	import rcfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctl_t  ctl,
	input  logic [7:0] byte_in,
	output logic [7:0] crc
);

	logic [7:0] crc_q;
	logic [7:0] crc_next;

	always_comb begin
		crc_next = crc_q ^ byte_in;
		for (int b = 0; b < 8; b++) begin
			crc_next = crc_next[7] ? ({crc_next[6:0], 1'b0} ^ CRC_POLY)
			                       : {crc_next[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.clear) begin
			crc_q <= '0;
		end else if (ctl.step) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule
